/* rtl/rmth_pkg.sv */
// Package: widths, payload structs and heap control types for the running median block.
package rmth_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int HEAP_DEPTH   = 128;
	localparam int ADDR_W       = $clog2(HEAP_DEPTH);
	localparam int CNT_W        = $clog2(HEAP_DEPTH + 1);
	localparam int TOT_W        = CNT_W + 1;
	localparam int COUNT_W      = 8;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic                           opcode;
		logic signed [SAMPLE_WIDTH-1:0] sample;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH:0] median_x2;
		logic                         empty_res;
		logic                         full_drop;
		logic [COUNT_W-1:0]           count;
	} result_t;

	typedef struct packed {
		logic                           push;
		logic                           pop;
		logic                           clear;
		logic signed [SAMPLE_WIDTH-1:0] value;
	} heap_cmd_t;

	typedef struct packed {
		logic                           busy;
		logic [CNT_W-1:0]               count;
		logic signed [SAMPLE_WIDTH-1:0] top;
		logic signed [SAMPLE_WIDTH-1:0] popped;
	} heap_stat_t;

endpackage

/* rtl/rmth_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module rmth_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/rmth_heap.sv */
// One binary heap in RAM with a sift-up push and a sift-down pop sequencer.
module rmth_heap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               is_max,
	input  rmth_pkg::heap_cmd_t cmd,
	output rmth_pkg::heap_stat_t stat
);
	import rmth_pkg::*;

	typedef enum logic [7:0] {
		H_IDLE   = 8'b0000_0001,
		H_UP_RD  = 8'b0000_0010,
		H_UP_CMP = 8'b0000_0100,
		H_DN_LST = 8'b0000_1000,
		H_DN_L   = 8'b0001_0000,
		H_DN_R   = 8'b0010_0000,
		H_DN_C   = 8'b0100_0000,
		H_DN_W   = 8'b1000_0000
	} hstate_t;

	hstate_t                  state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [ADDR_W-1:0]        i_q;
	logic [ADDR_W-1:0]        n_q;
	logic [ADDR_W-1:0]        bi_q;
	logic signed [SAMPLE_WIDTH-1:0] v_q, bv_q, top_q, popped_q;

	logic                     we;
	logic [ADDR_W-1:0]        waddr, raddr, parent;
	logic signed [SAMPLE_WIDTH-1:0] wdata, rdata;
	logic [ADDR_W:0]          lidx;
	logic [ADDR_W+1:0]        ridx;

	function automatic logic above(input logic signed [SAMPLE_WIDTH-1:0] a,
			input logic signed [SAMPLE_WIDTH-1:0] b, input logic mx);
		return mx ? (a > b) : (a < b);
	endfunction

	assign parent = (i_q - ADDR_W'(1)) >> 1;
	assign lidx   = {i_q, 1'b1};
	assign ridx   = {1'b0, lidx} + (ADDR_W+2)'(1);

	rmth_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HEAP_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// read address and write port
	always_comb begin
		raddr = parent;
		we    = 1'b0;
		waddr = i_q;
		wdata = v_q;
		case (state_q)
			H_IDLE: begin
				raddr = ADDR_W'(cnt_q - CNT_W'(1));
			end
			H_UP_RD: begin
				we = (i_q == '0);
			end
			H_UP_CMP: begin
				we    = 1'b1;
				wdata = above(v_q, rdata, is_max) ? rdata : v_q;
			end
			H_DN_L: begin
				raddr = lidx[ADDR_W-1:0];
				we    = (lidx >= {1'b0, n_q});
			end
			H_DN_R: begin
				raddr = ridx[ADDR_W-1:0];
			end
			H_DN_W: begin
				we    = 1'b1;
				wdata = (bi_q == i_q) ? v_q : bv_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				H_IDLE: begin
					if (cmd.clear) begin
						cnt_q <= '0;
					end else if (cmd.push) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= H_UP_RD;
					end else if (cmd.pop) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= H_DN_LST;
					end
				end
				H_UP_RD: begin
					state_q <= (i_q == '0) ? H_IDLE : H_UP_CMP;
				end
				H_UP_CMP: begin
					state_q <= above(v_q, rdata, is_max) ? H_UP_RD : H_IDLE;
				end
				H_DN_LST: state_q <= H_DN_L;
				H_DN_L: begin
					state_q <= (lidx >= {1'b0, n_q}) ? H_IDLE : H_DN_R;
				end
				H_DN_R: begin
					state_q <= (ridx < {2'b0, n_q}) ? H_DN_C : H_DN_W;
				end
				H_DN_C: state_q <= H_DN_W;
				H_DN_W: begin
					state_q <= (bi_q == i_q) ? H_IDLE : H_DN_L;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			top_q <= wdata;
		end
		case (state_q)
			H_IDLE: begin
				if (cmd.push) begin
					v_q <= cmd.value;
					i_q <= ADDR_W'(cnt_q);
				end else if (cmd.pop) begin
					popped_q <= top_q;
					n_q      <= ADDR_W'(cnt_q - CNT_W'(1));
				end
			end
			H_UP_CMP: begin
				if (above(v_q, rdata, is_max)) begin
					i_q <= parent;
				end
			end
			H_DN_LST: begin
				v_q <= rdata;
				i_q <= '0;
			end
			H_DN_R: begin
				if (above(rdata, v_q, is_max)) begin
					bv_q <= rdata;
					bi_q <= lidx[ADDR_W-1:0];
				end else begin
					bv_q <= v_q;
					bi_q <= i_q;
				end
			end
			H_DN_C: begin
				if (above(rdata, bv_q, is_max)) begin
					bv_q <= rdata;
					bi_q <= ridx[ADDR_W-1:0];
				end
			end
			H_DN_W: begin
				i_q <= bi_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.busy   = (state_q != H_IDLE);
	assign stat.count  = cnt_q;
	assign stat.top    = top_q;
	assign stat.popped = popped_q;

endmodule

/* rtl/running_median_two_heap.sv */
// Top level: running median over a max-heap and a min-heap kept in RAM.
// Usage:
//   Items (opcode, sample) arrive on the item channel: a transaction happens
//   at a clock edge with item_valid high and item_stall low. opcode 0 inserts
//   a sample, opcode 1 empties the store. Every item yields one result
//   transaction on the result channel: twice the median, an empty flag, a
//   dropped-on-full flag and the sample count after the item.
//   Sequence: a clear or a dropped insert goes straight to the result; an
//   insert sifts up one heap level by level, and a rebalance adds a
//   sift-down of the one heap plus a sift-up into the other heap. Both heaps
//   hold 128 entries, each in a RAM with a single read port. One item is
//   worked on at a time.
//   The finished result sits in an output register, so the next item is
//   taken while a result still waits on result_stall.
//   Reset empties both heaps (counts to zero) and drops any pending result;
//   heap RAM contents are not cleared and are never used before written.
module running_median_two_heap (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  rmth_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output rmth_pkg::result_t result
);
	import rmth_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INS  = 5'b00010,
		S_POP  = 5'b00100,
		S_MOVE = 5'b01000,
		S_RES  = 5'b10000
	} state_t;

	localparam logic [TOT_W-1:0] FULL_TOTAL = TOT_W'(2 * HEAP_DEPTH - 1);

	state_t     state_q;
	logic       drop_q;
	logic       to_upper_q;   // direction of the pending move: lower -> upper
	heap_cmd_t  lo_cmd, up_cmd;
	heap_stat_t lo_st, up_st;
	logic       accept, out_free;
	logic [TOT_W-1:0] total;
	logic signed [SAMPLE_WIDTH:0] med_x2, samp_x2;
	logic       go_lower;
	result_t    result_q;
	logic       result_valid_q;

	rmth_heap u_lower (
		.clk    (clk),
		.arst_n (arst_n),
		.is_max (1'b1),
		.cmd    (lo_cmd),
		.stat   (lo_st)
	);

	rmth_heap u_upper (
		.clk    (clk),
		.arst_n (arst_n),
		.is_max (1'b0),
		.cmd    (up_cmd),
		.stat   (up_st)
	);

	assign total = TOT_W'(lo_st.count) + TOT_W'(up_st.count);

	// twice the median from the cached heap tops
	always_comb begin
		if (total == '0) begin
			med_x2 = '0;
		end else if (lo_st.count == up_st.count) begin
			med_x2 = (SAMPLE_WIDTH+1)'(lo_st.top) + (SAMPLE_WIDTH+1)'(up_st.top);
		end else if (lo_st.count > up_st.count) begin
			med_x2 = {lo_st.top, 1'b0};
		end else begin
			med_x2 = {up_st.top, 1'b0};
		end
	end

	assign samp_x2  = {item.sample, 1'b0};
	assign go_lower = (total != '0) && (samp_x2 <= med_x2);

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && (state_q == S_IDLE);
	assign out_free   = !result_valid_q || !result_stall;

	// heap commands
	always_comb begin
		lo_cmd = '0;
		up_cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.opcode == OP_CLEAR) begin
						lo_cmd.clear = 1'b1;
						up_cmd.clear = 1'b1;
					end else if (total < FULL_TOTAL) begin
						lo_cmd.push  = go_lower;
						lo_cmd.value = item.sample;
						up_cmd.push  = !go_lower;
						up_cmd.value = item.sample;
					end
				end
			end
			S_INS: begin
				if (!lo_st.busy && !up_st.busy) begin
					lo_cmd.pop = (lo_st.count > up_st.count + CNT_W'(1));
					up_cmd.pop = (up_st.count > lo_st.count + CNT_W'(1));
				end
			end
			S_POP: begin
				if (!lo_st.busy && !up_st.busy) begin
					up_cmd.push  = to_upper_q;
					up_cmd.value = lo_st.popped;
					lo_cmd.push  = !to_upper_q;
					lo_cmd.value = up_st.popped;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			// load a new result, or retire the one taken by the receiver
			if (state_q == S_RES && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.opcode == OP_INSERT && total < FULL_TOTAL) begin
							state_q <= S_INS;
						end else begin
							state_q <= S_RES;
						end
					end
				end
				S_INS: begin
					if (!lo_st.busy && !up_st.busy) begin
						state_q <= (lo_cmd.pop || up_cmd.pop) ? S_POP : S_RES;
					end
				end
				S_POP: begin
					if (!lo_st.busy && !up_st.busy) begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					if (!lo_st.busy && !up_st.busy) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drop_q <= (item.opcode == OP_INSERT) && (total >= FULL_TOTAL);
		end
		if (state_q == S_INS) begin
			to_upper_q <= lo_cmd.pop;
		end
		if (state_q == S_RES && out_free) begin
			result_q.median_x2 <= med_x2;
			result_q.empty_res <= (total == '0);
			result_q.full_drop <= drop_q;
			result_q.count     <= COUNT_W'(total);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
